[sv/btff_pkg.sv]
`timescale 1ns / 1ps
// btff_pkg: constants and types for the boundary tag first fit allocator
// no dependencies

package btff_pkg;

    localparam int ArenaBytes = 32768;
    localparam int AddrW      = 15;
    localparam int TagW       = 16;
    localparam int LenW       = 17;

    localparam logic [LenW-1:0] TagBytes  = 17'd8;
    localparam logic [LenW-1:0] FirstHdr  = 17'd5;
    localparam logic [TagW-1:0] MinSplit  = 16'd10;
    localparam logic [TagW-1:0] MinArena  = 16'd14;
    localparam logic [LenW-1:0] MaxArena  = 17'd32768;
    localparam logic [TagW-1:0] HdrOverhd = 16'd13;

    typedef enum logic [1:0] {
        OP_INIT  = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2,
        OP_CHECK = 2'd3
    } t_op;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_RD   = 9'b000000010,
        S_EV   = 9'b000000100,
        S_FRD  = 9'b000001000,
        S_FEV  = 9'b000010000,
        S_FLRD = 9'b000100000,
        S_FLEV = 9'b001000000,
        S_FFIN = 9'b010000000,
        S_WR   = 9'b100000000
    } t_state;

endpackage

[sv/boundary_tag_first_fit_allocator.sv]
`timescale 1ns / 1ps
// boundary_tag_first_fit_allocator: first fit heap allocator with boundary tags
// depends on btff_pkg

// usage
// - s_axis carries one command per transaction: tuser holds the opcode
//   (init, allocate, free, check), tdata holds request size and block offset
// - m_axis returns exactly one result per command: tuser holds the status
//   bit (0 success), tdata holds the header offset of a new block
// - the cfg channel writes arena_size; it is always ready and is sampled
//   by the next init command
// - the tags live in a tag memory (one 16-bit entry per arena offset,
//   registered read); the byte contents of payloads are never stored
// - init writes the tags of one free block spanning the arena and posts
//   its result; allocate/check/free walk the block list one block at a
//   time, then free reads the neighbors, the tags are written back and
//   the result is posted; the walk over the tag memory port sets the rate
// - one command is in flight at a time; s_axis_tready is high only while
//   the engine is idle, and a new command is taken while a result still
//   sits in the output register
// - reset clears the initialized flag and the output register; the tag
//   memory is not cleared, commands before init return status 1
// - a stalled receiver holds the result in the output register and the
//   engine waits before posting the next one
module boundary_tag_first_fit_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // request_size[15:0], block_offset[30:16], zero
    input  logic [1:0]  s_axis_tuser,  // opcode[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // result_offset[14:0], zero
    output logic        m_axis_tuser,  // status[0]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);
    import btff_pkg::*;

    // tag memory
    logic signed [TagW-1:0] r_mem [ArenaBytes];
    logic signed [TagW-1:0] r_rd;
    logic [AddrW-1:0]       w_rd_addr;
    logic                   w_we;

    t_state                 r_state;
    t_op                    r_op;
    logic                   r_init_done;
    logic [15:0]            r_arena_size;
    logic [LenW-1:0]        r_end;
    logic [TagW-1:0]        r_req;
    logic [AddrW-1:0]       r_p;
    logic [LenW-1:0]        r_h;
    logic [TagW-1:0]        r_s;
    logic [AddrW-1:0]       r_start;
    logic [TagW-1:0]        r_size;
    logic [AddrW-1:0]       r_wa [4];
    logic signed [TagW-1:0] r_wd [4];
    logic [2:0]             r_wn;
    logic [2:0]             r_wi;
    logic                   r_status;
    logic [AddrW-1:0]       r_res;
    logic                   r_out_valid;
    logic                   r_out_status;
    logic [AddrW-1:0]       r_out_res;

    logic [TagW-1:0]        w_mag;
    logic [LenW-1:0]        w_hnext;
    logic [LenW-1:0]        w_rh;
    logic [TagW-1:0]        w_sat;
    logic [TagW-1:0]        w_u;
    logic                   w_fits;
    logic                   w_post;

    assign s_axis_tready = (r_state == S_IDLE) && !w_post;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {1'b0, r_out_res};

    // magnitude of the tag just read and the next header position
    assign w_mag   = r_rd[TagW-1] ? 16'(-r_rd) : 16'(r_rd);
    assign w_hnext = r_h + TagBytes + {1'b0, w_mag};
    assign w_rh    = {2'b00, r_p} + TagBytes + {1'b0, r_s};
    assign w_fits  = !r_rd[TagW-1] && (r_req <= 16'(r_rd));

    // init size clamped to the supported range
    always_comb begin
        if (r_arena_size < MinArena) begin
            w_sat = MinArena;
        end else if ({1'b0, r_arena_size} > MaxArena) begin
            w_sat = MaxArena[15:0];
        end else begin
            w_sat = r_arena_size;
        end
    end
    assign w_u = w_sat - HdrOverhd;

    // a finished result is posted when the output register is free
    assign w_post = (r_state == S_WR) && !(r_wi < r_wn) && (!r_out_valid || m_axis_tready);

    always_comb begin
        unique case (r_state)
            S_FRD:   w_rd_addr = w_rh[AddrW-1:0];
            S_FLRD:  w_rd_addr = r_p - 15'd4;
            default: w_rd_addr = r_h[AddrW-1:0];
        endcase
    end

    assign w_we = (r_state == S_WR) && (r_wi < r_wn);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_wa[r_wi[1:0]]] <= r_wd[r_wi[1:0]];
        end
        r_rd <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arena_size <= 16'd32768;
        end else if (i_cfg_valid) begin
            r_arena_size <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_init_done <= 1'b0;
            r_out_valid <= 1'b0;
            r_wn        <= '0;
            r_wi        <= '0;
        end else begin
            if (w_post) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_op     <= t_op'(s_axis_tuser);
                        r_req    <= s_axis_tdata[15:0];
                        r_p      <= s_axis_tdata[30:16];
                        r_h      <= FirstHdr;
                        r_res    <= '0;
                        r_wi     <= '0;
                        if (t_op'(s_axis_tuser) == OP_INIT) begin
                            r_wa[0]     <= FirstHdr[AddrW-1:0];
                            r_wd[0]     <= w_u;
                            r_wa[1]     <= AddrW'(w_sat - 16'd4);
                            r_wd[1]     <= w_u;
                            r_wn        <= 3'd2;
                            r_end       <= {1'b0, w_sat};
                            r_init_done <= 1'b1;
                            r_status    <= 1'b0;
                            r_state     <= S_WR;
                        end else begin
                            r_wn     <= '0;
                            r_status <= 1'b1;
                            if (!r_init_done || (t_op'(s_axis_tuser) == OP_ALLOC
                                && s_axis_tdata[15:0] == '0)) begin
                                r_state <= S_WR;
                            end else begin
                                r_state <= S_RD;
                            end
                        end
                    end
                end
                S_RD: begin
                    if (r_h + TagBytes > r_end) begin
                        r_state <= S_WR;
                    end else begin
                        r_state <= S_EV;
                    end
                end
                S_EV: begin
                    if (r_op == OP_ALLOC) begin
                        if (w_fits) begin
                            r_status <= 1'b0;
                            r_res    <= r_h[AddrW-1:0];
                            if (16'(r_rd) - r_req < MinSplit) begin
                                r_wa[0] <= r_h[AddrW-1:0];
                                r_wd[0] <= -r_rd;
                                r_wa[1] <= AddrW'(r_h + 17'd4 + {1'b0, w_mag});
                                r_wd[1] <= -r_rd;
                                r_wn    <= 3'd2;
                            end else begin
                                r_wa[0] <= r_h[AddrW-1:0];
                                r_wd[0] <= -r_req;
                                r_wa[1] <= AddrW'(r_h + 17'd4 + {1'b0, r_req});
                                r_wd[1] <= -r_req;
                                r_wa[2] <= AddrW'(r_h + TagBytes + {1'b0, r_req});
                                r_wd[2] <= 16'(r_rd) - r_req - 16'd8;
                                r_wa[3] <= AddrW'(r_h + 17'd4 + {1'b0, w_mag});
                                r_wd[3] <= 16'(r_rd) - r_req - 16'd8;
                                r_wn    <= 3'd4;
                            end
                            r_state <= S_WR;
                        end else begin
                            r_h     <= w_hnext;
                            r_state <= S_RD;
                        end
                    end else if (r_h == {2'b00, r_p}) begin
                        if (r_rd[TagW-1]) begin
                            if (r_op == OP_CHECK) begin
                                r_status <= 1'b0;
                                r_state  <= S_WR;
                            end else begin
                                r_s     <= w_mag;
                                r_size  <= w_mag;
                                r_start <= r_p;
                                r_state <= S_FRD;
                            end
                        end else begin
                            r_state <= S_WR;
                        end
                    end else if (r_h > {2'b00, r_p}) begin
                        r_state <= S_WR;
                    end else begin
                        r_h     <= w_hnext;
                        r_state <= S_RD;
                    end
                end
                S_FRD: begin
                    // right neighbor present only when its header fits
                    if (w_rh + TagBytes <= r_end) begin
                        r_state <= S_FEV;
                    end else begin
                        r_state <= S_FLRD;
                    end
                end
                S_FEV: begin
                    if (!r_rd[TagW-1]) begin
                        r_size <= r_size + 16'd8 + 16'(r_rd);
                    end
                    r_state <= S_FLRD;
                end
                S_FLRD: begin
                    if ({2'b00, r_p} > FirstHdr) begin
                        r_state <= S_FLEV;
                    end else begin
                        r_state <= S_FFIN;
                    end
                end
                S_FLEV: begin
                    if (!r_rd[TagW-1]) begin
                        r_start <= r_p - 15'd8 - AddrW'(r_rd);
                        r_size  <= r_size + 16'd8 + 16'(r_rd);
                    end
                    r_state <= S_FFIN;
                end
                S_FFIN: begin
                    r_wa[0]  <= r_start;
                    r_wd[0]  <= r_size;
                    r_wa[1]  <= r_start + 15'd4 + AddrW'(r_size);
                    r_wd[1]  <= r_size;
                    r_wn     <= 3'd2;
                    r_status <= 1'b0;
                    r_state  <= S_WR;
                end
                S_WR: begin
                    if (r_wi < r_wn) begin
                        r_wi <= r_wi + 3'd1;
                    end else if (w_post) begin
                        r_out_status <= r_status;
                        r_out_res    <= r_res;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_idle_no_writes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EV) |-> (r_wn == 3'd0))
        else $error("write queue not empty during walk");
    a_walk_in_arena: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EV) |-> (r_h + TagBytes <= r_end))
        else $error("tag read beyond arena end");
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");
    a_walk_needs_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |-> r_init_done)
        else $error("walk before init");
`endif

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// tb: self-checking bench for boundary_tag_first_fit_allocator, driving commands and
// checking every result against a tag-level heap predictor held inside the bench
// depends on btff_pkg and boundary_tag_first_fit_allocator

module tb;
    import btff_pkg::*;

    localparam int IDLE_LIMIT = 60000;   // cycles with no transaction before giving up

    typedef struct {
        logic        status;
        logic [14:0] offset;
    } t_answer;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // request_size[15:0], block_offset[30:16], zero
    logic [1:0]  s_axis_tuser;   // opcode[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // result_offset[14:0], zero
    logic        m_axis_tuser;   // status[0]
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data;

    boundary_tag_first_fit_allocator i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    // heap mirror: byte image of the arena plus init flag and size register
    bit   [7:0]  heap_mem [0:ArenaBytes-1];
    bit          heap_ready;
    logic [15:0] arena_reg;

    t_answer     answer_q[$];     // results still owed by the block
    int          live_blocks[$];  // headers currently allocated
    int          fail_cnt;
    int          cmd_cnt;
    int          op_cnt [4];
    int          result_cnt;
    bit          idle_en;         // random gaps on both sides
    int          hold_cycles;     // receiver hold-off, counted down by its own process
    int          quiet_cycles;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // 32-bit little-endian signed tag, zero outside the arena
    function automatic longint tag_get(longint pos);
        bit [31:0] u;
        longint    a;
        u = 0;
        for (int k = 3; k >= 0; k--) begin
            a = pos + k;
            u = u << 8;
            if (a >= 0 && a < ArenaBytes) u[7:0] = heap_mem[a];
        end
        return longint'(int'(u));
    endfunction

    function automatic void tag_put(longint pos, longint v);
        bit [31:0] u;
        longint    a;
        u = v[31:0];
        for (int k = 0; k < 4; k++) begin
            a = pos + k;
            if (a >= 0 && a < ArenaBytes) heap_mem[a] = u[7:0];
            u = u >> 8;
        end
    endfunction

    function automatic longint size_of(longint t);
        return (t < 0) ? -t : t;
    endfunction

    // one past the last usable byte, clamped to the arena
    function automatic longint heap_limit();
        longint e;
        e = tag_get(1) + 13;
        if (e > ArenaBytes) e = ArenaBytes;
        return e;
    endfunction

    function automatic bit is_owned_header(longint p);
        longint lim, h, t;
        lim = heap_limit();
        h = FirstHdr;
        while (h + TagBytes <= lim) begin
            t = tag_get(h);
            if (h == p) return (t < 0);
            if (h > p) return 1'b0;
            h = h + TagBytes + size_of(t);
        end
        return 1'b0;
    endfunction

    function automatic t_answer heap_apply(t_op op, logic [15:0] req_w, logic [14:0] off_w);
        t_answer r;
        longint  req, p, s, u, lim, h, t, rem, start, sz, rh, rt, lt;
        req = req_w;
        p   = off_w;
        r.status = 1'b1;
        r.offset = '0;
        case (op)
            OP_INIT: begin
                s = arena_reg;
                if (s < MinArena) s = MinArena;
                if (s > ArenaBytes) s = ArenaBytes;
                u = s - 13;
                heap_mem[0] = 8'h24;   // '$' marker
                tag_put(1, u);
                tag_put(FirstHdr, u);
                tag_put(FirstHdr + 4 + u, u);
                heap_ready = 1'b1;
                r.status = 1'b0;
            end
            OP_ALLOC: begin
                if (heap_ready && req > 0) begin
                    lim = heap_limit();
                    h = FirstHdr;
                    while (h + TagBytes <= lim) begin
                        t = tag_get(h);
                        if (t >= 0 && req <= t) begin
                            if (t - req < MinSplit) begin
                                // remainder too small to carry its own tags
                                tag_put(h, -t);
                                tag_put(h + 4 + t, -t);
                            end else begin
                                rem = t - req - TagBytes;
                                tag_put(h, -req);
                                tag_put(h + 4 + req, -req);
                                tag_put(h + TagBytes + req, rem);
                                tag_put(h + 4 + t, rem);
                            end
                            r.status = 1'b0;
                            r.offset = h[14:0];
                            break;
                        end
                        h = h + TagBytes + size_of(t);
                    end
                end
            end
            OP_FREE: begin
                if (heap_ready && is_owned_header(p)) begin
                    lim   = heap_limit();
                    s     = -tag_get(p);
                    start = p;
                    sz    = s;
                    rh    = p + TagBytes + s;
                    if (rh + TagBytes <= lim) begin
                        rt = tag_get(rh);
                        if (rt >= 0) begin
                            tag_put(p + 4 + s, 0);
                            tag_put(rh, 0);
                            sz = sz + TagBytes + rt;
                        end
                    end
                    if (p > FirstHdr) begin
                        lt = tag_get(p - 4);
                        if (lt >= 0) begin
                            tag_put(p - 4, 0);
                            tag_put(p, 0);
                            start = p - TagBytes - lt;
                            sz    = sz + TagBytes + lt;
                        end
                    end
                    tag_put(start, sz);
                    tag_put(start + 4 + sz, sz);
                    r.status = 1'b0;
                end
            end
            default: begin
                if (heap_ready && is_owned_header(p)) r.status = 1'b0;
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // driving and checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        fail_cnt++;
    endtask

    // offer one command; predicts its result at the accepting edge
    task automatic send_cmd(t_op op, logic [15:0] req, logic [14:0] off);
        t_answer a;
        int      idx;
        @(negedge i_clk);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = op;
        s_axis_tdata  = {1'b0, off, req};
        do @(posedge i_clk); while (!s_axis_tready);
        a = heap_apply(op, req, off);
        answer_q.push_back(a);
        cmd_cnt++;
        op_cnt[op]++;
        // keep the list of allocated headers in step with the mirror
        if (op == OP_INIT) live_blocks.delete();
        if (op == OP_ALLOC && a.status == 1'b0) live_blocks.push_back(int'(a.offset));
        if (op == OP_FREE && a.status == 1'b0) begin
            idx = -1;
            foreach (live_blocks[i]) if (live_blocks[i] == int'(off)) idx = i;
            if (idx >= 0) live_blocks.delete(idx);
        end
    endtask

    task automatic stop_sending();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    // register write, only while the block is idle
    task automatic write_arena_size(logic [15:0] v);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = v;
        do @(posedge i_clk); while (!o_cfg_ready);
        arena_reg = v;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic drain();
        stop_sending();
        wait (answer_q.size() == 0);
        repeat (16) @(posedge i_clk);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_answer e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            result_cnt++;
            if (answer_q.size() == 0) begin
                report_mismatch("result transaction with nothing outstanding");
            end else begin
                e = answer_q.pop_front();
                if (m_axis_tuser !== e.status)
                    report_mismatch($sformatf("status %b, wanted %b", m_axis_tuser, e.status));
                if (m_axis_tdata[14:0] !== e.offset)
                    report_mismatch($sformatf("offset %0d, wanted %0d",
                                              m_axis_tdata[14:0], e.offset));
            end
        end
    end

    // receiver: long hold-off when asked, random stall bursts otherwise
    initial begin
        int burst;
        burst = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                m_axis_tready = 1'b0;
                hold_cycles--;
            end else if (burst > 0) begin
                m_axis_tready = 1'b0;
                burst--;
            end else if (idle_en && $urandom_range(0, 4) == 0) begin
                m_axis_tready = 1'b0;
                burst = $urandom_range(0, 15);
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    // watchdog on cycles with no transaction on any channel
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // commands before any init must all fail
    task automatic test_uninitialized();
        send_cmd(OP_ALLOC, 16'd8, 15'd0);
        send_cmd(OP_FREE,  16'd0, 15'd5);
        send_cmd(OP_CHECK, 16'd0, 15'd5);
        drain();
    endtask

    // size extremes, zero and oversize requests, bad frees, both merge sides
    task automatic test_directed();
        int a, b, c;
        write_arena_size(16'd0);        // saturates up to the smallest arena
        send_cmd(OP_INIT,  16'd0, 15'd0);
        send_cmd(OP_ALLOC, 16'd1, 15'd0);   // takes the whole one-byte block
        send_cmd(OP_ALLOC, 16'd1, 15'd0);   // nothing left
        send_cmd(OP_CHECK, 16'd0, 15'd5);
        send_cmd(OP_CHECK, 16'd0, 15'd6);
        send_cmd(OP_FREE,  16'd0, 15'd6);   // not on a block boundary
        send_cmd(OP_FREE,  16'd0, 15'd5);
        send_cmd(OP_FREE,  16'd0, 15'd5);   // already free
        drain();
        write_arena_size(16'hFFFF);     // saturates down to the full arena
        send_cmd(OP_INIT,  16'd0, 15'd0);
        send_cmd(OP_ALLOC, 16'd0, 15'd0);       // zero-size request
        send_cmd(OP_ALLOC, 16'h8000, 15'd0);    // larger than the arena
        send_cmd(OP_ALLOC, 16'hFFFF, 15'd0);
        send_cmd(OP_ALLOC, 16'd32755, 15'd0);   // exactly the whole arena
        send_cmd(OP_CHECK, 16'd0, 15'h7FFF);
        send_cmd(OP_FREE,  16'd0, 15'd5);
        drain();
        write_arena_size(16'd14);
        send_cmd(OP_INIT, 16'd0, 15'd0);
        drain();
        write_arena_size(16'd32768);
        send_cmd(OP_INIT, 16'd0, 15'd0);
        // three neighbors: free left, then right, then middle merges on both sides
        a = 5;
        b = a + 8 + 100;
        c = b + 8 + 100;
        send_cmd(OP_ALLOC, 16'd100, 15'd0);
        send_cmd(OP_ALLOC, 16'd100, 15'd0);
        send_cmd(OP_ALLOC, 16'd100, 15'd0);
        send_cmd(OP_FREE,  16'd0, 15'(a));
        send_cmd(OP_FREE,  16'd0, 15'(c));   // merges with the free tail
        send_cmd(OP_FREE,  16'd0, 15'(b));   // merges on both sides
        send_cmd(OP_ALLOC, 16'd32755, 15'd0);
        drain();
    endtask

    // mostly valid alloc/free/check traffic on live blocks, some noise
    task automatic random_phase(logic [15:0] size, int n);
        int sel, cap;
        logic [14:0] off;
        write_arena_size(size);
        send_cmd(OP_INIT, 16'd0, 15'd0);
        cap = (size > 16) ? size / 6 : 2;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(0, 99);
            if (live_blocks.size() > 0)
                off = 15'(live_blocks[$urandom_range(0, live_blocks.size() - 1)]);
            else
                off = 15'(FirstHdr);
            if (sel < 45) begin
                if ($urandom_range(0, 19) == 0)
                    send_cmd(OP_ALLOC, 16'($urandom), off);
                else
                    send_cmd(OP_ALLOC, 16'($urandom_range(1, cap)), off);
            end else if (sel < 80) begin
                if ($urandom_range(0, 4) == 0) off = 15'($urandom);
                send_cmd(OP_FREE, 16'($urandom), off);
            end else if (sel < 96) begin
                if ($urandom_range(0, 2) == 0) off = 15'($urandom);
                send_cmd(OP_CHECK, 16'($urandom), off);
            end else begin
                send_cmd(OP_INIT, 16'($urandom), 15'($urandom));
            end
        end
        drain();
    endtask

    // receiver stalls long while commands keep coming, block must back up
    task automatic test_backpressure();
        write_arena_size(16'd2048);
        send_cmd(OP_INIT, 16'd0, 15'd0);
        drain();
        hold_cycles = 400;
        for (int i = 0; i < 20; i++) send_cmd(OP_ALLOC, 16'($urandom_range(1, 60)), 15'd0);
        drain();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_INIT;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        heap_ready    = 1'b0;
        arena_reg     = 16'd32768;
        fail_cnt      = 0;
        cmd_cnt       = 0;
        result_cnt    = 0;
        hold_cycles   = 0;
        quiet_cycles  = 0;
        idle_en       = 1'b1;
        op_cnt        = '{default: 0};
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_uninitialized();
        test_directed();
        random_phase(16'd14,    30);
        random_phase(16'd64,    80);
        random_phase(16'd300,  160);
        random_phase(16'd1000, 180);
        random_phase(16'd4096, 150);
        random_phase(16'd32768, 80);
        test_backpressure();
        idle_en = 1'b0;                 // closing stretch at full rate
        random_phase(16'd700, 150);

        $display("ran %0d commands (init %0d, alloc %0d, free %0d, check %0d), %0d results",
                 cmd_cnt, op_cnt[0], op_cnt[1], op_cnt[2], op_cnt[3], result_cnt);
        $display("arena sizes from the minimum to the full arena, %0d mismatches", fail_cnt);
        if (fail_cnt == 0 && answer_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[sim.f]
sv/btff_pkg.sv
sv/boundary_tag_first_fit_allocator.sv
verif/tb.sv
